@@ hw/rtl/dns_query_builder_unit_defines.svh @@
// assertion macros for the dns query builder
// used by the top level only; expects clk and rst_n in scope
`ifndef DNS_QUERY_BUILDER_UNIT_DEFINES_SVH
`define DNS_QUERY_BUILDER_UNIT_DEFINES_SVH

// same-cycle implication
`define DQB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DQB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/dnsqb_pkg.sv @@
// shared constants, types and byte functions of the dns query builder
// no dependencies
`default_nettype none

package dnsqb_pkg;

  localparam int BYTE_W        = 8;
  localparam int WORD_W        = 16;
  localparam int MAX_LABEL_DEF = 56;
  localparam int ADDR_W        = 4;
  localparam int DATA_W        = 32;
  localparam int CNT_W         = 4;

  localparam logic [BYTE_W-1:0] CHAR_DOT = 8'h2e;

  localparam logic [CNT_W-1:0] HDR_LAST  = 4'd11;
  localparam logic [CNT_W-1:0] TAIL_LAST = 4'd4;

  localparam logic [1:0] REG_QUERY_ID     = 2'd0;
  localparam logic [1:0] REG_HEADER_FLAGS = 2'd1;
  localparam logic [1:0] REG_QUERY_TYPE   = 2'd2;
  localparam logic [1:0] REG_QUERY_CLASS  = 2'd3;

  localparam logic [WORD_W-1:0] RST_QUERY_ID     = 16'h0001;
  localparam logic [WORD_W-1:0] RST_HEADER_FLAGS = 16'h0100;
  localparam logic [WORD_W-1:0] RST_QUERY_TYPE   = 16'h0001;
  localparam logic [WORD_W-1:0] RST_QUERY_CLASS  = 16'h0001;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic push;
    logic pop;
  } chain_cmd_t;

  // header: id, flags, qdcount = 1, three zero counts
  function automatic logic [BYTE_W-1:0] hdr_byte(input logic [CNT_W-1:0] idx,
                                                 input logic [WORD_W-1:0] qid,
                                                 input logic [WORD_W-1:0] flags);
    logic [BYTE_W-1:0] b;
    unique case (idx)
      4'd0:    b = qid[15:8];
      4'd1:    b = qid[7:0];
      4'd2:    b = flags[15:8];
      4'd3:    b = flags[7:0];
      4'd5:    b = 8'h01;
      default: b = '0;
    endcase
    return b;
  endfunction

  // tail: root terminator, qtype, qclass
  function automatic logic [BYTE_W-1:0] tail_byte(input logic [CNT_W-1:0] idx,
                                                  input logic [WORD_W-1:0] qtype,
                                                  input logic [WORD_W-1:0] qclass);
    logic [BYTE_W-1:0] b;
    unique case (idx)
      4'd1:    b = qtype[15:8];
      4'd2:    b = qtype[7:0];
      4'd3:    b = qclass[15:8];
      4'd4:    b = qclass[7:0];
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dns_query_builder_unit.sv @@
// A plain character is taken without leaving idle, so the next can follow.
// The first character of a name adds 12 header bytes; a dot or the last character
// flushes the label as a length byte and its characters; the end adds 5 tail bytes.
// One byte leaves per cycle while out_stall is low; the single output register sets the rate.
// Reset: synchronous, active low; registers return to id 1, flags 0x0100, type 1, class 1,
// label buffer empty; the cell contents are not cleared and need no clearing pass.
`default_nettype none
`include "dns_query_builder_unit_defines.svh"

module dns_query_builder_unit #(
  parameter int MAX_LABEL = dnsqb_pkg::MAX_LABEL_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,

  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [dnsqb_pkg::BYTE_W-1:0]      in_name_char,
  input  wire logic                              in_name_last,

  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [dnsqb_pkg::BYTE_W-1:0]      out_byte,
  output logic                                   out_last,
  output logic                                   out_label_overflow,

  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [dnsqb_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [dnsqb_pkg::DATA_W-1:0]      pwdata,
  output logic      [dnsqb_pkg::DATA_W-1:0]      prdata,
  output logic                                   pready
);

  localparam int FILL_W = $clog2(MAX_LABEL + 1);
  localparam logic [FILL_W-1:0] MAX_FILL = FILL_W'(MAX_LABEL);
  localparam logic [FILL_W-1:0] ONE_FILL = FILL_W'(1);
  localparam logic [dnsqb_pkg::CNT_W-1:0] ONE_CNT = dnsqb_pkg::CNT_W'(1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HDR  = 3'd1;
  localparam logic [2:0] ST_LEN  = 3'd2;
  localparam logic [2:0] ST_DATA = 3'd3;
  localparam logic [2:0] ST_TAIL = 3'd4;

  // config registers
  logic [dnsqb_pkg::WORD_W-1:0] qid_r, flags_r, qtype_r, qclass_r;
  logic                         cfg_wr;
  logic [1:0]                   cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qid_r    <= dnsqb_pkg::RST_QUERY_ID;
      flags_r  <= dnsqb_pkg::RST_HEADER_FLAGS;
      qtype_r  <= dnsqb_pkg::RST_QUERY_TYPE;
      qclass_r <= dnsqb_pkg::RST_QUERY_CLASS;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        dnsqb_pkg::REG_QUERY_ID:     qid_r    <= pwdata[15:0];
        dnsqb_pkg::REG_HEADER_FLAGS: flags_r  <= pwdata[15:0];
        dnsqb_pkg::REG_QUERY_TYPE:   qtype_r  <= pwdata[15:0];
        dnsqb_pkg::REG_QUERY_CLASS:  qclass_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      dnsqb_pkg::REG_QUERY_ID:     prdata = {16'b0, qid_r};
      dnsqb_pkg::REG_HEADER_FLAGS: prdata = {16'b0, flags_r};
      dnsqb_pkg::REG_QUERY_TYPE:   prdata = {16'b0, qtype_r};
      dnsqb_pkg::REG_QUERY_CLASS:  prdata = {16'b0, qclass_r};
      default:                     prdata = '0;
    endcase
  end

  // control state
  logic [2:0]                  state_r, state_nxt;
  logic [dnsqb_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [FILL_W-1:0]           fill_r, fill_nxt;
  logic                        hdr_sent_r, hdr_sent_nxt;
  logic                        ovf_r, ovf_nxt;
  logic                        dot_r, dot_nxt;
  logic                        last_r, last_nxt;
  logic                        out_valid_r, out_valid_nxt;

  logic [dnsqb_pkg::BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic                         out_last_r, out_last_nxt;
  logic                         out_ovf_r, out_ovf_nxt;

  logic                         in_acc;
  logic                         in_dot;
  logic                         emitting;
  logic                         emit;
  logic                         tail_done;
  logic [dnsqb_pkg::BYTE_W-1:0] head;
  dnsqb_pkg::chain_cmd_t        cmd;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign in_dot    = (in_name_char == dnsqb_pkg::CHAR_DOT);
  assign emitting  = (state_r != ST_IDLE);
  assign emit      = emitting && (!out_valid_r || !out_stall);
  assign tail_done = emit && (state_r == ST_TAIL) && (cnt_r == dnsqb_pkg::TAIL_LAST);

  assign cmd.push = in_acc && !in_dot && (fill_r < MAX_FILL);
  assign cmd.pop  = emit && (state_r == ST_DATA);

  dnsqb_chain #(
    .MAX_LABEL (MAX_LABEL),
    .FILL_W    (FILL_W)
  ) u_chain (
    .clk     (clk),
    .cmd     (cmd),
    .wr_idx  (fill_r),
    .wr_char (in_name_char),
    .head    (head)
  );

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    fill_nxt     = fill_r;
    hdr_sent_nxt = hdr_sent_r;
    ovf_nxt      = ovf_r;
    dot_nxt      = dot_r;
    last_nxt     = last_r;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;
    out_ovf_nxt  = out_ovf_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;

    if (in_acc) begin
      dot_nxt      = in_dot;
      last_nxt     = in_name_last;
      hdr_sent_nxt = 1'b1;
      cnt_nxt      = '0;
      if (cmd.push) begin
        fill_nxt = fill_r + ONE_FILL;
      end else if (!in_dot) begin
        ovf_nxt = 1'b1;
      end
      priority if (!hdr_sent_r) begin
        state_nxt = ST_HDR;
      end else if (in_dot || in_name_last) begin
        state_nxt = ST_LEN;
      end else begin
        state_nxt = ST_IDLE;
      end
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = 1'b0;
      out_ovf_nxt   = 1'b0;
      unique case (state_r)
        ST_HDR: begin
          out_byte_nxt = dnsqb_pkg::hdr_byte(cnt_r, qid_r, flags_r);
          if (cnt_r == dnsqb_pkg::HDR_LAST) begin
            cnt_nxt   = '0;
            state_nxt = (dot_r || last_r) ? ST_LEN : ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + ONE_CNT;
          end
        end
        ST_LEN, ST_DATA: begin
          if (state_r == ST_LEN) begin
            out_byte_nxt = dnsqb_pkg::BYTE_W'(fill_r);
          end else begin
            out_byte_nxt = head;
            fill_nxt     = fill_r - ONE_FILL;
          end
          if ((state_r == ST_LEN && fill_r != '0) ||
              (state_r == ST_DATA && fill_r != ONE_FILL)) begin
            state_nxt = ST_DATA;
          end else if (dot_r && last_r) begin
            dot_nxt   = 1'b0;
            state_nxt = ST_LEN;
          end else if (last_r) begin
            cnt_nxt   = '0;
            state_nxt = ST_TAIL;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
        ST_TAIL: begin
          out_byte_nxt = dnsqb_pkg::tail_byte(cnt_r, qtype_r, qclass_r);
          if (cnt_r == dnsqb_pkg::TAIL_LAST) begin
            out_last_nxt = 1'b1;
            out_ovf_nxt  = ovf_r;
            cnt_nxt      = '0;
            fill_nxt     = '0;
            hdr_sent_nxt = 1'b0;
            ovf_nxt      = 1'b0;
            state_nxt    = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + ONE_CNT;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      fill_r      <= '0;
      hdr_sent_r  <= 1'b0;
      ovf_r       <= 1'b0;
      dot_r       <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fill_r      <= fill_nxt;
      hdr_sent_r  <= hdr_sent_nxt;
      ovf_r       <= ovf_nxt;
      dot_r       <= dot_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_byte           = out_byte_r;
  assign out_last           = out_last_r;
  assign out_label_overflow = out_ovf_r;

  // checks
  `DQB_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= MAX_FILL, "label fill beyond buffer")
  `DQB_ASSERT_NOW(a_data_nonempty, state_r == ST_DATA, fill_r != '0, "replay from empty label")
  `DQB_ASSERT_NOW(a_ovf_on_last, out_valid_r && out_ovf_r, out_last_r, "overflow off last byte")
  `DQB_ASSERT_NEXT(a_end_clears, tail_done, fill_r == '0 && !hdr_sent_r && !ovf_r, "end state kept")

endmodule

`default_nettype wire

@@ hw/rtl/dnsqb_cell.sv @@
// one byte cell of the label chain: loads a character or takes its neighbour's byte
// depends on dnsqb_pkg
`default_nettype none

module dnsqb_cell (
  input  wire logic                          clk,
  input  wire dnsqb_pkg::cell_ctl_t          ctl,
  input  wire logic [dnsqb_pkg::BYTE_W-1:0]  din,
  input  wire logic [dnsqb_pkg::BYTE_W-1:0]  nbr,
  output logic      [dnsqb_pkg::BYTE_W-1:0]  q
);

  logic [dnsqb_pkg::BYTE_W-1:0] data_r;
  logic [dnsqb_pkg::BYTE_W-1:0] data_nxt;

  always_comb begin
    priority if (ctl.load) begin
      data_nxt = din;
    end else if (ctl.shift) begin
      data_nxt = nbr;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

`default_nettype wire

@@ hw/rtl/dnsqb_chain.sv @@
// label buffer as a row of byte cells; head of the row is the oldest character
// depends on dnsqb_pkg and dnsqb_cell
`default_nettype none

module dnsqb_chain #(
  parameter int MAX_LABEL = dnsqb_pkg::MAX_LABEL_DEF,
  parameter int FILL_W    = $clog2(MAX_LABEL + 1)
) (
  input  wire logic                          clk,
  input  wire dnsqb_pkg::chain_cmd_t         cmd,
  input  wire logic [FILL_W-1:0]             wr_idx,
  input  wire logic [dnsqb_pkg::BYTE_W-1:0]  wr_char,
  output logic      [dnsqb_pkg::BYTE_W-1:0]  head
);

  logic [dnsqb_pkg::BYTE_W-1:0] q   [MAX_LABEL];
  logic [dnsqb_pkg::BYTE_W-1:0] nbr [MAX_LABEL];

  for (genvar i = 0; i < MAX_LABEL; i++) begin : g_cell
    dnsqb_pkg::cell_ctl_t ctl;

    assign ctl.load  = cmd.push && (wr_idx == FILL_W'(i));
    assign ctl.shift = cmd.pop;

    if (i == MAX_LABEL - 1) begin : g_tail
      assign nbr[i] = '0;
    end else begin : g_mid
      assign nbr[i] = q[i+1];
    end

    dnsqb_cell u_cell (
      .clk (clk),
      .ctl (ctl),
      .din (wr_char),
      .nbr (nbr[i]),
      .q   (q[i])
    );
  end

  assign head = q[0];

endmodule

`default_nettype wire
